FILE: design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc assertion failed");

`endif

FILE: design/pcc_pkg.sv
package pcc_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int WIDE_W = DATA_W + 2;
    localparam int ALPHA_W = 17;
    localparam int TIME_W = 31;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // clamp limits in fixed point
    localparam wide_t LIM_ES   = wide_t'(360 * (2 ** FRAC_W));
    localparam wide_t LIM_IO0  = wide_t'(100 * (2 ** FRAC_W));
    localparam wide_t LIM_IO1  = wide_t'(200 * (2 ** FRAC_W));
    localparam wide_t LIM_D    = wide_t'(500 * (2 ** FRAC_W));
    localparam wide_t LIM_DRV0 = wide_t'(800 * (2 ** FRAC_W));
    localparam wide_t LIM_DRV1 = wide_t'(500 * (2 ** FRAC_W));
    localparam wide_t ONE_Q    = wide_t'(2 ** FRAC_W);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(2 ** FRAC_W);

    // register map, one word apart
    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_SETPOINT = 3'd1,
        REG_KP       = 3'd2,
        REG_KI       = 3'd3,
        REG_KD       = 3'd4,
        REG_ALPHA    = 3'd5,
        REG_STEP     = 3'd6,
        REG_INV_STEP = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                mode;
        data_t               setpoint;
        data_t               kp;
        data_t               ki;
        data_t               kd;
        logic [ALPHA_W-1:0]  alpha;
        logic [TIME_W-1:0]   step_time;
        logic [TIME_W-1:0]   inv_step_time;
    } cfg_t;

    // request to the serial multiplier
    typedef struct packed {
        logic                  start;
        data_t                 a;
        logic signed [DATA_W:0] b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        data_t prod;
    } mul_rsp_t;

    // saturate a wide value to the data width
    function automatic data_t sat_data(input wide_t x);
        data_t r;
        if ((&x[WIDE_W-1:DATA_W-1]) || !(|x[WIDE_W-1:DATA_W-1])) begin
            r = x[DATA_W-1:0];
        end else if (x[WIDE_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // symmetric clamp, a value at or beyond the limit becomes the limit
    function automatic wide_t clamp_sym(input wide_t x, input wide_t l);
        wide_t r;
        if (x >= l) begin
            r = l;
        end else if (x <= -l) begin
            r = -l;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

FILE: design/pcc_serial_mul.sv
`include "assert_macros.svh"

module pcc_serial_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcc_pkg::mul_req_t req,
    output pcc_pkg::mul_rsp_t rsp
);
    import pcc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam int RND_W = PROD_W - FRAC_W + 1;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_RUN  = 4'b0010,
        M_RND  = 4'b0100,
        M_NEG  = 4'b1000
    } mstate_t;

    mstate_t             state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   ua_reg, mag_reg, mag_next;
    logic                neg_reg, done_reg;
    data_t               prod_reg;

    logic [DATA_W-1:0]   ua_in, ub_in, lim;
    logic [DATA_W:0]     b_abs, part_sum;
    logic [RND_W-1:0]    rnd_sum;
    logic                last_bit;

    // operand magnitudes and per-step arithmetic
    always_comb begin
        ua_in    = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
        b_abs    = req.b[DATA_W] ? (~req.b + 1'b1) : req.b;
        ub_in    = b_abs[DATA_W-1:0];
        part_sum = {1'b0, acc_reg[PROD_W-1:DATA_W]}
                 + (acc_reg[0] ? {1'b0, ua_reg} : {(DATA_W+1){1'b0}});
        rnd_sum  = {1'b0, acc_reg[PROD_W-1:FRAC_W]}
                 + {{(RND_W-1){1'b0}}, (neg_reg & (|acc_reg[FRAC_W-1:0]))};
        lim      = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        mag_next = (rnd_sum > {{(RND_W-DATA_W){1'b0}}, lim}) ? lim : rnd_sum[DATA_W-1:0];
        last_bit = (cnt_reg == CNT_W'(DATA_W - 1));
    end

    // sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: begin
                if (req.start) state_next = M_RUN;
            end
            M_RUN: begin
                if (last_bit) state_next = M_RND;
            end
            M_RND:   state_next = M_NEG;
            M_NEG:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_NEG);
        end
    end

    // shift-add datapath, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    ua_reg  <= ua_in;
                    acc_reg <= {{DATA_W{1'b0}}, ub_in};
                    neg_reg <= req.a[DATA_W-1] ^ req.b[DATA_W];
                    cnt_reg <= '0;
                end
            end
            M_RUN: begin
                acc_reg <= {part_sum, acc_reg[DATA_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            M_RND: begin
                mag_reg <= mag_next;
            end
            M_NEG: begin
                prod_reg <= neg_reg ? data_t'(~mag_reg + 1'b1) : data_t'(mag_reg);
            end
            default: begin
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

    `PCC_ASSERT_IMP(a_start_when_idle, aclk, aresetn, req.start, state_reg == M_IDLE)
    `PCC_ASSERT_NXT(a_run_ends, aclk, aresetn, state_reg == M_RUN && last_bit, state_reg == M_RND)
    `PCC_ASSERT_NXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg)

endmodule

FILE: design/pcc_ctrl.sv
`include "assert_macros.svh"

module pcc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcc_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcc_pkg::data_t    s_measured,
    input  pcc_pkg::data_t    s_rate_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [26:0] m_drive,
    output logic signed [31:0] m_p_term,
    output logic signed [24:0] m_i_term,
    output logic signed [25:0] m_d_term,
    output pcc_pkg::mul_req_t mul_req,
    input  pcc_pkg::mul_rsp_t mul_rsp
);
    import pcc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_WAIT = 7'b0001000,
        S_SUM1 = 7'b0010000,
        S_SUM2 = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    // products in issue order
    typedef enum logic [2:0] {
        OP_P    = 3'd0,
        OP_I0   = 3'd1,
        OP_D0   = 3'd2,
        OP_RATE = 3'd3,
        OP_FILT = 3'd4,
        OP_EKI  = 3'd5,
        OP_INC  = 3'd6,
        OP_D1   = 3'd7
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   m_valid_reg;

    // controller state
    data_t  es_reg, io_reg, fr_reg, lm_reg;

    // per-transaction working registers
    data_t  meas_reg, rate_reg, err_reg, diff_reg;
    data_t  p_reg, i_reg, d_reg, tmp_reg;
    data_t  it_reg, dt_reg, dsel_reg, drive_reg;
    wide_t  s1_reg;

    logic signed [26:0] m_drive_reg;
    logic signed [31:0] m_p_term_reg;
    logic signed [24:0] m_i_term_reg;
    logic signed [25:0] m_d_term_reg;

    logic [ALPHA_W-1:0] alpha_c;
    wide_t  prod_w, s_full, drv_c;
    data_t  es_upd, fdiff, fr_upd, io_upd, it_sel, dt_c, drive_val;
    logic   out_load;

    // operand selection for the shared multiplier
    always_comb begin
        alpha_c       = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        mul_req.start = (state_reg == S_MUL);
        mul_req.a     = err_reg;
        mul_req.b     = {cfg.kp[DATA_W-1], cfg.kp};
        case (op_reg)
            OP_P: begin
                mul_req.a = err_reg;
                mul_req.b = {cfg.kp[DATA_W-1], cfg.kp};
            end
            OP_I0: begin
                mul_req.a = es_reg;
                mul_req.b = {cfg.ki[DATA_W-1], cfg.ki};
            end
            OP_D0: begin
                mul_req.a = rate_reg;
                mul_req.b = {cfg.kd[DATA_W-1], cfg.kd};
            end
            OP_RATE: begin
                mul_req.a = diff_reg;
                mul_req.b = {2'b00, cfg.inv_step_time};
            end
            OP_FILT: begin
                mul_req.a = tmp_reg;
                mul_req.b = {{(DATA_W+1-ALPHA_W){1'b0}}, alpha_c};
            end
            OP_EKI: begin
                mul_req.a = err_reg;
                mul_req.b = {cfg.ki[DATA_W-1], cfg.ki};
            end
            OP_INC: begin
                mul_req.a = tmp_reg;
                mul_req.b = {2'b00, cfg.step_time};
            end
            OP_D1: begin
                mul_req.a = fr_reg;
                mul_req.b = {cfg.kd[DATA_W-1], cfg.kd};
            end
            default: begin
            end
        endcase
    end

    // saturating updates applied as each product returns
    always_comb begin
        prod_w = wide_t'(mul_rsp.prod);
        es_upd = data_t'(clamp_sym(wide_t'(sat_data(wide_t'(es_reg) + wide_t'(err_reg))),
                                   LIM_ES));
        fdiff  = sat_data(prod_w - wide_t'(fr_reg));
        fr_upd = sat_data(wide_t'(fr_reg) + prod_w);
        io_upd = data_t'(clamp_sym(wide_t'(sat_data(wide_t'(io_reg) + prod_w)), LIM_IO1));
    end

    // output terms and final sum
    always_comb begin
        it_sel    = cfg.mode ? io_reg : data_t'(clamp_sym(wide_t'(i_reg), LIM_IO0));
        dt_c      = data_t'(clamp_sym(wide_t'(d_reg), LIM_D));
        s_full    = s1_reg + wide_t'(dsel_reg);
        drv_c     = clamp_sym(s_full, cfg.mode ? LIM_DRV1 : LIM_DRV0);
        drive_val = data_t'(drv_c);
        if (!cfg.mode && drv_c < ONE_Q && drv_c > -ONE_Q) begin
            drive_val = '0;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_PREP;
            end
            S_PREP: begin
                state_next = S_MUL;
                op_next    = OP_P;
            end
            S_MUL: state_next = S_WAIT;
            S_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = S_MUL;
                    case (op_reg)
                        OP_P:    op_next = cfg.mode ? OP_RATE : OP_I0;
                        OP_I0:   op_next = OP_D0;
                        OP_RATE: op_next = OP_FILT;
                        OP_FILT: op_next = OP_EKI;
                        OP_EKI:  op_next = OP_INC;
                        OP_INC:  op_next = OP_D1;
                        OP_D0, OP_D1: begin
                            state_next = S_SUM1;
                        end
                        default: state_next = S_SUM1;
                    endcase
                end
            end
            S_SUM1: state_next = S_SUM2;
            S_SUM2: state_next = S_DONE;
            S_DONE: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and controller state, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_P;
            m_valid_reg <= 1'b0;
            es_reg      <= '0;
            io_reg      <= '0;
            fr_reg      <= '0;
            lm_reg      <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_PREP) begin
                lm_reg <= meas_reg;
            end
            if (state_reg == S_WAIT && mul_rsp.done) begin
                case (op_reg)
                    OP_P: begin
                        if (!cfg.mode) es_reg <= es_upd;
                    end
                    OP_FILT: fr_reg <= fr_upd;
                    OP_INC:  io_reg <= io_upd;
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_SUM1) begin
                io_reg <= it_sel;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                meas_reg <= s_measured;
                rate_reg <= s_rate_in;
            end
            S_PREP: begin
                err_reg  <= sat_data(wide_t'(meas_reg) - wide_t'(cfg.setpoint));
                diff_reg <= sat_data(wide_t'(meas_reg) - wide_t'(lm_reg));
            end
            S_WAIT: begin
                if (mul_rsp.done) begin
                    case (op_reg)
                        OP_P:    p_reg   <= mul_rsp.prod;
                        OP_I0:   i_reg   <= mul_rsp.prod;
                        OP_D0:   d_reg   <= mul_rsp.prod;
                        OP_RATE: tmp_reg <= fdiff;
                        OP_EKI:  tmp_reg <= mul_rsp.prod;
                        OP_D1:   d_reg   <= mul_rsp.prod;
                        default: begin
                        end
                    endcase
                end
            end
            S_SUM1: begin
                it_reg   <= it_sel;
                dt_reg   <= dt_c;
                s1_reg   <= wide_t'(p_reg) + (cfg.mode ? wide_t'(io_reg) : wide_t'(i_reg));
                dsel_reg <= cfg.mode ? dt_c : d_reg;
            end
            S_SUM2: begin
                drive_reg <= drive_val;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_drive_reg  <= drive_reg[26:0];
            m_p_term_reg <= p_reg;
            m_i_term_reg <= it_reg[24:0];
            m_d_term_reg <= dt_reg[25:0];
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_drive  = m_drive_reg;
    assign m_p_term = m_p_term_reg;
    assign m_i_term = m_i_term_reg;
    assign m_d_term = m_d_term_reg;

    `PCC_ASSERT_IMP(a_done_only_waiting, aclk, aresetn, mul_rsp.done, state_reg == S_WAIT)
    `PCC_ASSERT_NXT(a_prep_starts_p, aclk, aresetn, state_reg == S_PREP, state_reg == S_MUL && op_reg == OP_P)
    `PCC_ASSERT_NXT(a_load_shows_valid, aclk, aresetn, out_load, m_valid_reg && state_reg == S_IDLE)

endmodule

FILE: design/pid_controller_clamped_core.sv
// each product runs on one bit-serial multiplier at one bit per cycle
// mode 0 takes three products per transaction, mode 1 takes six
// one transaction is in flight at a time; the next is taken while a result waits at m_*
// aresetn (synchronous, active low) clears the controller state and restores register defaults
module pid_controller_clamped_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_measured,
    input  logic signed [31:0] s_rate_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [26:0] m_drive,
    output logic signed [31:0] m_p_term,
    output logic signed [24:0] m_i_term,
    output logic signed [25:0] m_d_term
);
    import pcc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= 1'b0;
            cfg_reg.setpoint      <= '0;
            cfg_reg.kp            <= '0;
            cfg_reg.ki            <= '0;
            cfg_reg.kd            <= '0;
            cfg_reg.alpha         <= ALPHA_ONE;
            cfg_reg.step_time     <= '0;
            cfg_reg.inv_step_time <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:     cfg_reg.mode          <= pwdata[0];
                REG_SETPOINT: cfg_reg.setpoint      <= pwdata;
                REG_KP:       cfg_reg.kp            <= pwdata;
                REG_KI:       cfg_reg.ki            <= pwdata;
                REG_KD:       cfg_reg.kd            <= pwdata;
                REG_ALPHA:    cfg_reg.alpha         <= pwdata[ALPHA_W-1:0];
                REG_STEP:     cfg_reg.step_time     <= pwdata[TIME_W-1:0];
                REG_INV_STEP: cfg_reg.inv_step_time <= pwdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (reg_idx)
            REG_MODE:     prdata = {31'b0, cfg_reg.mode};
            REG_SETPOINT: prdata = cfg_reg.setpoint;
            REG_KP:       prdata = cfg_reg.kp;
            REG_KI:       prdata = cfg_reg.ki;
            REG_KD:       prdata = cfg_reg.kd;
            REG_ALPHA:    prdata = {{(32-ALPHA_W){1'b0}}, cfg_reg.alpha};
            REG_STEP:     prdata = {{(32-TIME_W){1'b0}}, cfg_reg.step_time};
            REG_INV_STEP: prdata = {{(32-TIME_W){1'b0}}, cfg_reg.inv_step_time};
            default:      prdata = '0;
        endcase
    end

    // transaction sequencer and output register
    pcc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_rate_in  (s_rate_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_p_term   (m_p_term),
        .m_i_term   (m_i_term),
        .m_d_term   (m_d_term),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp)
    );

    // shared bit-serial multiplier
    pcc_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

endmodule

FILE: verif/pid_controller_clamped_core_test.sv
`timescale 1ns / 100ps

module pid_controller_clamped_core_test;

    import pcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned GAP_MAX     = 240;
    localparam int unsigned DRAIN_WAIT  = 260;
    localparam int unsigned PHASES      = 16;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned MAX_REPORTS = 10;

    // one controller output, at the widths of the result ports
    typedef struct packed {
        logic signed [26:0] drive;
        logic signed [31:0] p_term;
        logic signed [24:0] i_term;
        logic signed [25:0] d_term;
    } pid_out_t;

    // one row of the directed part: a register write or a measurement
    typedef struct {
        bit                 is_write;
        reg_idx_t           idx;
        logic [31:0]        val;
        logic signed [31:0] meas;
        logic signed [31:0] rate;
        bit                 fixed;
        pid_out_t           want;
    } plan_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_measured = '0;
    logic signed [31:0] s_rate_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [26:0] m_drive;
    logic signed [31:0] m_p_term;
    logic signed [24:0] m_i_term;
    logic signed [25:0] m_d_term;

    // shadow registers and controller state
    cfg_t   ctrl_cfg;
    longint acc_err = 0;
    longint held_integral = 0;
    longint smooth_rate = 0;
    longint prev_meas = 0;

    pid_out_t    pending_outputs[$];
    plan_row_t   steps_plan[$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    pid_controller_clamped_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_rate_in  (s_rate_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_p_term   (m_p_term),
        .m_i_term   (m_i_term),
        .m_d_term   (m_d_term)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // fixed point helpers
    function automatic longint sat_bits(input longint x, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint mul_q(input longint a, input longint b, input int sh);
        return sat_bits((a * b) >>> sh, DATA_W);
    endfunction

    function automatic longint clamp_q(input longint x, input longint lim);
        longint l;
        l = lim * (longint'(1) <<< FRAC_W);
        if (x >= l) return l;
        if (x <= -l) return -l;
        return x;
    endfunction

    // one controller step on the shadow state
    function automatic pid_out_t advance_controller(input logic signed [31:0] meas_in,
                                                    input logic signed [31:0] rate_in);
        longint meas, err, p, full_i, full_d, it, dt, drv, a, slope, g_p, g_i, g_d, one;
        pid_out_t r;
        one  = longint'(1) <<< FRAC_W;
        g_p  = longint'(signed'(ctrl_cfg.kp));
        g_i  = longint'(signed'(ctrl_cfg.ki));
        g_d  = longint'(signed'(ctrl_cfg.kd));
        meas = meas_in;
        err  = sat_bits(meas - longint'(signed'(ctrl_cfg.setpoint)), DATA_W);
        p    = mul_q(err, g_p, FRAC_W);
        if (!ctrl_cfg.mode) begin
            // error sum and supplied rate, terms summed unclamped, then deadband
            acc_err       = clamp_q(sat_bits(acc_err + err, DATA_W), 360);
            full_i        = mul_q(acc_err, g_i, FRAC_W);
            full_d        = mul_q(longint'(rate_in), g_d, FRAC_W);
            it            = clamp_q(full_i, 100);
            dt            = clamp_q(full_d, 500);
            held_integral = it;
            drv           = clamp_q(p + full_i + full_d, 800);
            if (drv < one && drv > -one) begin
                drv = 0;
            end
        end else begin
            // filtered difference and output-side integral
            a = longint'(ctrl_cfg.alpha);
            if (a > longint'(ALPHA_ONE)) begin
                a = longint'(ALPHA_ONE);
            end
            slope = mul_q(sat_bits(meas - prev_meas, DATA_W),
                          longint'(ctrl_cfg.inv_step_time), FRAC_W);
            smooth_rate = sat_bits(smooth_rate +
                                   mul_q(sat_bits(slope - smooth_rate, DATA_W), a, FRAC_W),
                                   DATA_W);
            held_integral = clamp_q(sat_bits(held_integral +
                                             mul_q(mul_q(err, g_i, FRAC_W),
                                                   longint'(ctrl_cfg.step_time), FRAC_W),
                                             DATA_W), 200);
            it  = held_integral;
            dt  = clamp_q(mul_q(smooth_rate, g_d, FRAC_W), 500);
            drv = clamp_q(p + it + dt, 500);
        end
        prev_meas = meas;
        r.drive  = 27'(sat_bits(drv, 27));
        r.p_term = 32'(sat_bits(p, 32));
        r.i_term = 25'(sat_bits(it, 25));
        r.d_term = 26'(sat_bits(dt, 26));
        return r;
    endfunction

    function automatic void note_fault(input string what, input longint want, input longint got);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // directed rows
    function automatic void plan_write(input reg_idx_t idx, input logic [31:0] val);
        plan_row_t row;
        row = '{default: '0, idx: REG_MODE};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.val      = val;
        steps_plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic [31:0] meas, input logic [31:0] rate);
        plan_row_t row;
        row = '{default: '0, idx: REG_MODE};
        row.meas = meas;
        row.rate = rate;
        steps_plan.push_back(row);
    endfunction

    function automatic void plan_fixed(input logic [31:0] meas, input logic [31:0] rate,
                                       input longint drive, input longint p,
                                       input longint i, input longint d);
        plan_row_t row;
        row = '{default: '0, idx: REG_MODE};
        row.meas        = meas;
        row.rate        = rate;
        row.fixed       = 1'b1;
        row.want.drive  = 27'(drive);
        row.want.p_term = 32'(p);
        row.want.i_term = 25'(i);
        row.want.d_term = 26'(d);
        steps_plan.push_back(row);
    endfunction

    // random words: mostly within +-span, some corners, some anything
    function automatic logic [31:0] roll_word(input int unsigned span);
        logic [31:0] w;
        case ($urandom_range(9))
            0: w = $urandom;
            1: begin
                case ($urandom_range(4))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0000_0000;
                    3: w = 32'h0001_0000;
                    default: w = 32'hFFFF_0000;
                endcase
            end
            default: w = $urandom_range(0, 2 * span) - span;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] roll_period();
        logic [31:0] w;
        case ($urandom_range(4))
            0: w = $urandom;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'($urandom_range(0, 32'h0010_0000));
            default: w = 32'($urandom_range(1, 32'h0000_1000));
        endcase
        return w;
    endfunction

    // register write, setup then access phase
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_MODE:     ctrl_cfg.mode          = val[0];
            REG_SETPOINT: ctrl_cfg.setpoint      = val;
            REG_KP:       ctrl_cfg.kp            = val;
            REG_KI:       ctrl_cfg.ki            = val;
            REG_KD:       ctrl_cfg.kd            = val;
            REG_ALPHA:    ctrl_cfg.alpha         = val[ALPHA_W-1:0];
            REG_STEP:     ctrl_cfg.step_time     = val[TIME_W-1:0];
            REG_INV_STEP: ctrl_cfg.inv_step_time = val[TIME_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait until every pending output has come back
    task automatic settle();
        while (pending_outputs.size() != 0) @(negedge aclk);
    endtask

    // offer one measurement, predict at acceptance
    task automatic offer_item(input logic signed [31:0] meas, input logic signed [31:0] rate,
                              input bit fixed, input pid_out_t want);
        pid_out_t calc;
        if (!steady && $urandom_range(99) < 19) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_measured = meas;
        s_rate_in  = rate;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        calc = advance_controller(meas, rate);
        pending_outputs.push_back(fixed ? want : calc);
        @(negedge aclk);
        // accepted, so withdraw valid until the next transaction
        s_valid = 1'b0;
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready = steady || ($urandom_range(99) >= 19);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_outputs
        pid_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                note_fault("unexpected result drive", 0, m_drive);
            end else begin
                want = pending_outputs.pop_front();
                if (m_drive !== want.drive) note_fault("drive", want.drive, m_drive);
                if (m_p_term !== want.p_term) note_fault("p_term", want.p_term, m_p_term);
                if (m_i_term !== want.i_term) note_fault("i_term", want.i_term, m_i_term);
                if (m_d_term !== want.d_term) note_fault("d_term", want.d_term, m_d_term);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t          row;
        pid_out_t           none;
        logic [31:0]        junk;
        logic [16:0]        alpha_v;
        logic signed [31:0] walk;
        logic signed [31:0] meas;
        int unsigned        walk_span;
        int unsigned        rate_span;

        none = '0;
        ctrl_cfg = '0;
        ctrl_cfg.alpha = ALPHA_ONE;

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // all gains zero after reset, then rails and deadband edges
        plan_fixed(32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        plan_fixed(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        plan_fixed(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        plan_write(REG_KP, 32'h0001_0000);
        plan_fixed(32'h7FFF_FFFF, 32'h0000_0000, 52428800, 32'sh7FFF_FFFF, 0, 0);
        plan_fixed(32'h8000_0000, 32'h0000_0000, -52428800, -2147483648, 0, 0);
        plan_fixed(32'h0000_FFFF, 32'h0000_0000, 0, 65535, 0, 0);
        plan_fixed(32'h0001_0000, 32'h0000_0000, 65536, 65536, 0, 0);
        plan_fixed(32'hFFFF_0000, 32'h0000_0000, -65536, -65536, 0, 0);
        plan_fixed(32'hFFFF_0001, 32'h0000_0000, 0, -65535, 0, 0);
        // integral and derivative clamps with saturating error
        plan_write(REG_SETPOINT, 32'h0005_0000);
        plan_write(REG_KI, 32'h0001_0000);
        plan_write(REG_KD, 32'h0001_0000);
        plan_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        plan_item(32'h8000_0000, 32'h8000_0000);
        plan_item(32'h0005_0000, 32'h0000_0000);
        plan_item(32'h0005_8000, 32'hFFFF_8000);
        // extreme gains
        plan_write(REG_KP, 32'h8000_0000);
        plan_write(REG_KI, 32'h7FFF_FFFF);
        plan_write(REG_KD, 32'h8000_0000);
        plan_item(32'h8000_0000, 32'h7FFF_FFFF);
        plan_item(32'h7FFF_FFFF, 32'h8000_0000);
        plan_item(32'h0000_0000, 32'hFFFF_FFFF);
        // filtered mode, alpha above one, largest periods, state carried over
        plan_write(REG_STEP, 32'h7FFF_FFFF);
        plan_write(REG_INV_STEP, 32'h7FFF_FFFF);
        plan_write(REG_ALPHA, 32'h0001_FFFF);
        plan_write(REG_MODE, 32'h0000_0001);
        plan_write(REG_KP, 32'h0001_0000);
        plan_write(REG_KI, 32'h0001_0000);
        plan_write(REG_KD, 32'h0001_0000);
        plan_item(32'h7FFF_FFFF, 32'h0000_0000);
        plan_item(32'h8000_0000, 32'h0000_0000);
        plan_item(32'h0006_0000, 32'h0000_0000);
        plan_item(32'h0005_0000, 32'h0000_0000);
        // alpha zero holds the filter
        plan_write(REG_ALPHA, 32'h0000_0000);
        plan_item(32'h0010_0000, 32'h0000_0000);
        plan_item(32'h0000_0000, 32'h0000_0000);
        // half filtering, realistic periods
        plan_write(REG_ALPHA, 32'h0000_8000);
        plan_write(REG_STEP, 32'h0000_0042);
        plan_write(REG_INV_STEP, 32'h03E8_0000);
        plan_item(32'h0005_1000, 32'h0000_0000);
        plan_item(32'h0005_2000, 32'h0000_0000);
        // back to supplied rate with the error sum kept
        plan_write(REG_MODE, 32'h0000_0000);
        plan_item(32'h0005_0000, 32'h0002_0000);

        foreach (steps_plan[k]) begin
            row = steps_plan[k];
            if (row.is_write) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                offer_item(row.meas, row.rate, row.fixed, row.want);
            end
        end

        // random phases, each with its own settings
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            settle();
            s_valid = 1'b0;
            steady  = (ph == 6);
            junk    = $urandom;
            write_reg(REG_MODE, {junk[31:1], 1'(ph % 2)});
            write_reg(REG_SETPOINT, roll_word(32'h0064_0000));
            write_reg(REG_KP, roll_word(32'h0002_0000));
            write_reg(REG_KI, roll_word(32'h0002_0000));
            write_reg(REG_KD, roll_word(32'h0002_0000));
            case ($urandom_range(3))
                0: alpha_v = 17'd0;
                1: alpha_v = ALPHA_ONE;
                2: alpha_v = 17'($urandom_range(32'h0001_0001, 32'h0001_FFFF));
                default: alpha_v = 17'($urandom_range(0, 32'h0001_0000));
            endcase
            junk = $urandom;
            write_reg(REG_ALPHA, {junk[31:17], alpha_v});
            write_reg(REG_STEP, roll_period());
            write_reg(REG_INV_STEP, roll_period());

            walk      = ctrl_cfg.setpoint;
            walk_span = $urandom_range(16, 32'h0004_0000);
            rate_span = $urandom_range(1, 32'h0080_0000);
            for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
                // mostly a slow drift around the setpoint, some jumps
                case ($urandom_range(9))
                    0: meas = $urandom;
                    1: meas = roll_word(32'h0100_0000);
                    default: begin
                        walk = walk + ($urandom_range(0, 2 * walk_span) - walk_span);
                        meas = walk;
                    end
                endcase
                offer_item(meas, roll_word(rate_span), 1'b0, none);
            end
        end

        // drain
        s_valid = 1'b0;
        steady  = 1'b0;
        settle();
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
